/* rtl/stable_priority_queue_defines.svh */
// ----------------------------------------------------------------------------
// stable priority queue assertion macros
// concurrent checks clocked on clk, quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SPQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spq check failed");
// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spq check failed");
`else
`define SPQ_ASSERT_IMP(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes of the stable priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

	// request kinds carried in the input tuser
	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	typedef enum logic {
		ST_EMPTY,
		ST_HOLD
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic do_enq;
		logic do_deq;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} dp_status_t;

endpackage

/* rtl/stable_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded sorted queue, highest priority first, arrival order among equals
// ----------------------------------------------------------------------------
// usage:
//   slave channel s_*: one request word per handshake. s_tuser selects the
//   request (0 enqueue, 1 dequeue), s_tdata carries tag and priority.
//   master channel m_*: exactly one result word per request, in order.
//   m_tuser flags whether the enqueue was stored or the dequeue returned an
//   entry; m_tdata gives the removed tag and priority (zero if none) and the
//   entry count after the request.
// latency: the result word is valid the cycle after the request is taken.
// throughput: one request per cycle while results are taken; every slot checks the
//   new priority at once; slots behind the new entry (all on a dequeue) shift by one.
// stall: while a result waits and m_tready is low, s_tready is low too and
//   the store does not move; when the result is taken in a cycle, the next
//   request can be taken in that same cycle.
// reset: arst_n empties the queue (count to zero); slot contents are left
//   as they are and only slots below the count are ever compared or returned.
// an enqueue on a full queue and a dequeue on an empty one leave the store
// unchanged and report so in m_tuser.
// ----------------------------------------------------------------------------

module stable_priority_queue #(
	parameter int CAPACITY  = 16,
	parameter int PRIO_BITS = 8,
	parameter int TAG_BITS  = 16,
	localparam int CNT_W    = $clog2(CAPACITY + 1),
	localparam int IN_W     = ((TAG_BITS + PRIO_BITS + 7) / 8) * 8,
	localparam int OUT_W    = ((TAG_BITS + PRIO_BITS + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// request words
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // tag, priority_req, zero fill
	input  logic             s_tuser,   // req_type
	// result words
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // deq_tag, deq_priority, occupancy, zero fill
	output logic [1:0]       m_tuser    // enq_accepted, deq_valid
);
	import spq_pkg::*;

	dp_cmd_t              cmd;
	dp_status_t           status;
	logic [TAG_BITS-1:0]  in_tag;
	logic [PRIO_BITS-1:0] in_prio;
	logic                 enq_accepted;
	logic                 deq_valid;
	logic [TAG_BITS-1:0]  deq_tag;
	logic [PRIO_BITS-1:0] deq_priority;
	logic [CNT_W-1:0]     occupancy;

	// unpack the request word
	assign in_tag  = s_tdata[TAG_BITS-1:0];
	assign in_prio = s_tdata[TAG_BITS+PRIO_BITS-1:TAG_BITS];

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	spq_dp #(
		.CAPACITY  (CAPACITY),
		.PRIO_BITS (PRIO_BITS),
		.TAG_BITS  (TAG_BITS),
		.CNT_W     (CNT_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.tag          (in_tag),
		.priority_req (in_prio),
		.enq_accepted (enq_accepted),
		.deq_valid    (deq_valid),
		.deq_tag      (deq_tag),
		.deq_priority (deq_priority),
		.occupancy    (occupancy)
	);

	// pack the result word, lowest field first
	assign m_tdata = OUT_W'({occupancy, deq_priority, deq_tag});
	assign m_tuser = {deq_valid, enq_accepted};

endmodule

/* rtl/spq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// handshake controller: owns the output word register state, issues commands
// ----------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module spq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                req_type,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  spq_pkg::dp_status_t status,
	output spq_pkg::dp_cmd_t    cmd
);
	import spq_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_EMPTY: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				m_tvalid = 1'b1;
				s_tready = m_tready;
				if (m_tready && !s_tvalid) begin
					state_d = ST_EMPTY;
				end
			end
			default: begin
				state_d = ST_EMPTY;
			end
		endcase
		accept     = s_tvalid && s_tready;
		cmd.load   = accept;
		cmd.do_enq = accept && (req_type == REQ_ENQ) && !status.full;
		cmd.do_deq = accept && (req_type == REQ_DEQ) && !status.empty;
	end

	// every accepted word leaves a result waiting
	`SPQ_ASSERT_NEXT(a_accept_holds, accept, state_q == ST_HOLD)
	// a waiting result only goes away once taken
	`SPQ_ASSERT_NEXT(a_hold_kept, (state_q == ST_HOLD) && !m_tready, state_q == ST_HOLD)

endmodule

/* rtl/spq_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_dp
// sorted shift-register store with per-slot compare, and the result register
// ----------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module spq_dp #(
	parameter int CAPACITY  = 16,
	parameter int PRIO_BITS = 8,
	parameter int TAG_BITS  = 16,
	parameter int CNT_W     = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spq_pkg::dp_cmd_t     cmd,
	output spq_pkg::dp_status_t  status,
	input  logic [TAG_BITS-1:0]  tag,
	input  logic [PRIO_BITS-1:0] priority_req,
	output logic                 enq_accepted,
	output logic                 deq_valid,
	output logic [TAG_BITS-1:0]  deq_tag,
	output logic [PRIO_BITS-1:0] deq_priority,
	output logic [CNT_W-1:0]     occupancy
);
	import spq_pkg::*;

	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

	logic [PRIO_BITS-1:0] prio_q [CAPACITY];
	logic [TAG_BITS-1:0]  tag_q  [CAPACITY];
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_d;
	logic [CAPACITY-1:0]  ge;

	assign status.full  = (count_q == CAP);
	assign status.empty = (count_q == '0);

	always_comb begin
		count_d = count_q;
		if (cmd.do_enq) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.do_deq) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// each slot decides from its own compare and that of its neighbour toward the head
	for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
		assign ge[i] = (CNT_W'(i) < count_q) && (prio_q[i] >= priority_req);

		always_ff @(posedge clk) begin
			if (cmd.do_enq && !ge[i]) begin
				if (i == 0) begin
					prio_q[i] <= priority_req;
					tag_q[i]  <= tag;
				end else if (ge[(i == 0) ? 0 : i-1]) begin
					prio_q[i] <= priority_req;
					tag_q[i]  <= tag;
				end else begin
					prio_q[i] <= prio_q[(i == 0) ? 0 : i-1];
					tag_q[i]  <= tag_q[(i == 0) ? 0 : i-1];
				end
			end else if (cmd.do_deq && (i < CAPACITY-1)) begin
				prio_q[i] <= prio_q[(i < CAPACITY-1) ? i+1 : i];
				tag_q[i]  <= tag_q[(i < CAPACITY-1) ? i+1 : i];
			end
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			enq_accepted <= cmd.do_enq;
			deq_valid    <= cmd.do_deq;
			deq_tag      <= cmd.do_deq ? tag_q[0] : '0;
			deq_priority <= cmd.do_deq ? prio_q[0] : '0;
			occupancy    <= count_d;
		end
	end

	`SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CAP)
	`SPQ_ASSERT_IMP(a_cmd_onehot, cmd.do_enq, !cmd.do_deq)
	`SPQ_ASSERT_IMP(a_enq_room, cmd.do_enq, count_q < CAP)
	`SPQ_ASSERT_NEXT(a_occ_tracks, cmd.load, occupancy == count_q)

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stable priority queue: a clocked driver feeds
// request words from a queue, a clocked monitor predicts each result from its
// own sorted copy of the store and compares every field of every result word
// ----------------------------------------------------------------------------

module tb_top;
	import spq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int IN_W        = 24;
	localparam int OUT_W       = 32;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;
	localparam int RAND_ITEMS  = 1275;

	// one request word as the bench sees it
	typedef struct packed {
		logic        kind;
		logic [15:0] tag;
		logic [7:0]  prio;
	} request_t;

	// one result word, field by field
	typedef struct packed {
		logic        enq_ok;
		logic        deq_ok;
		logic [15:0] tag;
		logic [7:0]  prio;
		logic [4:0]  count;
	} pq_result_t;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;   // tag, priority_req, zero fill
	logic             s_tuser  = 1'b0; // req_type
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;         // deq_tag, deq_priority, occupancy, zero fill
	logic [1:0]       m_tuser;         // enq_accepted, deq_valid

	stable_priority_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// stimulus and expectation stores
	request_t   pending_requests[$];
	pq_result_t results_due[$];

	int items_pushed = 0;
	int items_taken  = 0;
	int errors       = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_req     = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;

	// bench copy of the sorted store, slot 0 is the head
	logic [7:0]  pq_prio[QUEUE_DEPTH];
	logic [15:0] pq_tag[QUEUE_DEPTH];
	int          pq_count = 0;

	// apply one request to the bench store and return the word it should give
	function automatic pq_result_t apply_request(input request_t rq);
		pq_result_t r;
		int         pos;
		int         i;
		r = '0;
		if (rq.kind == REQ_ENQ) begin
			if (pq_count < QUEUE_DEPTH) begin
				// new entry goes behind every entry of greater or equal priority
				pos = 0;
				while (pos < pq_count && pq_prio[pos] >= rq.prio)
					pos++;
				for (i = pq_count; i > pos; i--) begin
					pq_prio[i] = pq_prio[i-1];
					pq_tag[i]  = pq_tag[i-1];
				end
				pq_prio[pos] = rq.prio;
				pq_tag[pos]  = rq.tag;
				pq_count++;
				r.enq_ok = 1'b1;
			end
		end else if (pq_count > 0) begin
			r.deq_ok = 1'b1;
			r.tag    = pq_tag[0];
			r.prio   = pq_prio[0];
			for (i = 0; i + 1 < pq_count; i++) begin
				pq_prio[i] = pq_prio[i+1];
				pq_tag[i]  = pq_tag[i+1];
			end
			pq_count--;
		end
		r.count = pq_count[4:0];
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s at %0t: got %0h, expected %0h", field, $realtime, got,
			want);
		errors++;
	endtask

	task automatic queue_request(input logic kind, input logic [15:0] tag,
			input logic [7:0] prio);
		request_t rq;
		rq.kind = kind;
		rq.tag  = tag;
		rq.prio = prio;
		pending_requests.push_back(rq);
		items_pushed++;
	endtask

	// priorities lean towards the extremes and a narrow band to force ties
	function automatic logic [7:0] pick_priority();
		logic [7:0] edges[6];
		int         sel;
		edges = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hfe, 8'hff};
		sel = $urandom_range(99);
		if (sel < 30)
			return edges[$urandom_range(5)];
		else if (sel < 60)
			return 8'h40 + 8'($urandom_range(3));
		return 8'($urandom);
	endfunction

	task automatic wait_drained;
		while (items_taken != items_pushed || results_due.size() != 0)
			@(posedge clk);
	endtask

	// one random phase: bursts of enqueue-heavy, dequeue-heavy or mixed words
	task automatic run_phase(input int src_pct, input int snk_pct, input int n,
			input bit with_hold);
		int start;
		int burst;
		int enq_pct;
		int k;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		start = items_pushed;
		while (items_pushed - start < n) begin
			burst = $urandom_range(40, 4);
			case ($urandom_range(2))
				0: enq_pct = 85;
				1: enq_pct = 15;
				default: enq_pct = 50;
			endcase
			for (k = 0; k < burst && items_pushed - start < n; k++)
				queue_request(($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ,
					16'($urandom), pick_priority());
		end
		if (with_hold) begin
			// long receiver stall once the phase is under way, sender keeps offering
			while (items_taken < start + n / 4)
				@(posedge clk);
			hold_req++;
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------------
	// driver: offers the head of pending_requests, holds it until taken
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : driver
		request_t rq;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				rq = pending_requests.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= rq.kind;
				s_tdata  <= {rq.prio, rq.tag};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure, or a long counted hold when asked
	always @(posedge clk) begin : receiver
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// monitor: checks each result word against the oldest expectation, then
	// predicts the word for any request taken at this edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		pq_result_t want;
		request_t   rq;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					report_mismatch("unexpected word", {m_tuser, m_tdata[29:0]}, '0);
				end else begin
					want = results_due.pop_front();
					if (m_tuser[0] !== want.enq_ok)
						report_mismatch("enq_accepted", 32'(m_tuser[0]), 32'(want.enq_ok));
					if (m_tuser[1] !== want.deq_ok)
						report_mismatch("deq_valid", 32'(m_tuser[1]), 32'(want.deq_ok));
					if (m_tdata[15:0] !== want.tag)
						report_mismatch("deq_tag", 32'(m_tdata[15:0]), 32'(want.tag));
					if (m_tdata[23:16] !== want.prio)
						report_mismatch("deq_priority", 32'(m_tdata[23:16]),
							32'(want.prio));
					if (m_tdata[28:24] !== want.count)
						report_mismatch("occupancy", 32'(m_tdata[28:24]), 32'(want.count));
				end
			end
			if (s_tvalid && s_tready) begin
				rq.kind = s_tuser;
				rq.tag  = s_tdata[15:0];
				rq.prio = s_tdata[23:16];
				results_due.push_back(apply_request(rq));
				items_taken++;
			end
		end
	end

	// watchdog: too long without a word moving on either side
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("stable_priority_queue test failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		src_idle_pct = 0;
		snk_idle_pct = 0;
		queue_request(REQ_DEQ, 16'hffff, 8'hff);  // dequeue from an empty queue
		queue_request(REQ_ENQ, 16'h0000, 8'h00);
		queue_request(REQ_ENQ, 16'hffff, 8'hff);
		queue_request(REQ_ENQ, 16'h0001, 8'h80);  // three equal priorities, fifo
		queue_request(REQ_ENQ, 16'h0002, 8'h80);
		queue_request(REQ_ENQ, 16'h0003, 8'h80);
		queue_request(REQ_ENQ, 16'h0004, 8'hff);  // ties with the head, goes behind
		queue_request(REQ_ENQ, 16'h0005, 8'h00);  // ties with the tail
		for (k = 0; k < 9; k++)
			queue_request(REQ_ENQ, 16'($urandom), 8'(k * 29));
		queue_request(REQ_ENQ, 16'haaaa, 8'hff);  // full queue, refused
		for (k = 0; k < 8; k++)
			queue_request(REQ_DEQ, 16'($urandom), 8'($urandom));
		wait_drained();

		// random part in three idling regimes
		run_phase(9, 79, RAND_ITEMS / 3, 1'b0);
		run_phase(79, 9, RAND_ITEMS / 3, 1'b0);
		run_phase(0, 0, RAND_ITEMS / 3, 1'b1);

		repeat (20) @(posedge clk);
		if (errors == 0 && results_due.size() == 0)
			$display("stable_priority_queue test passed");
		else
			$display("stable_priority_queue test failed");
		$finish;
	end

endmodule
